### sv/cts_pkg.sv
// Shared types, codes and lookup functions for the C-like token scanner.
package cts_pkg;

  // Default parameter values
  localparam int TOKEN_LEN_MAX_DEF = 255;
  localparam int KEYWORD_CHARS_DEF = 6;

  // Longest keyword body
  localparam int KW_CHARS = 6;
  localparam int KW_COUNT = 13;

  // Scan mode codes
  localparam logic [2:0] M_IDLE       = 3'd0;
  localparam logic [2:0] M_IDENT      = 3'd1;
  localparam logic [2:0] M_NUMBER     = 3'd2;
  localparam logic [2:0] M_STRING     = 3'd3;
  localparam logic [2:0] M_CHAR_OPEN  = 3'd4;
  localparam logic [2:0] M_CHAR_ESC   = 3'd5;
  localparam logic [2:0] M_CHAR_CLOSE = 3'd6;
  localparam logic [2:0] M_SYMBOL     = 3'd7;

  // Token kind codes
  localparam logic [5:0] KIND_NONE   = 6'd0;
  localparam logic [5:0] KIND_IDENT  = 6'd13;
  localparam logic [5:0] KIND_NUMBER = 6'd14;
  localparam logic [5:0] KIND_CHAR   = 6'd15;
  localparam logic [5:0] KIND_STRING = 6'd16;
  localparam logic [5:0] KIND_OP_LE  = 6'd32;
  localparam logic [5:0] KIND_OP_GE  = 6'd33;
  localparam logic [5:0] KIND_OP_EQ  = 6'd34;
  localparam logic [5:0] KIND_OP_NE  = 6'd35;

  // Error causes
  localparam logic CAUSE_UNMATCHED = 1'b0;
  localparam logic CAUSE_INVALID   = 1'b1;

  // Character codes
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;

  // Keyword bodies, first character in the lowest byte, zero padded
  localparam logic [KW_CHARS-1:0][7:0] KW_TEXT [KW_COUNT] = '{
    48'h00_74_73_6E_6F_63,  // const
    48'h00_00_00_74_6E_69,  // int
    48'h00_00_72_61_68_63,  // char
    48'h00_00_64_69_6F_76,  // void
    48'h00_00_6E_69_61_6D,  // main
    48'h00_00_00_00_66_69,  // if
    48'h00_00_65_73_6C_65,  // else
    48'h00_00_00_00_6F_64,  // do
    48'h00_65_6C_69_68_77,  // while
    48'h00_00_00_72_6F_66,  // for
    48'h00_66_6E_61_63_73,  // scanf
    48'h66_74_6E_69_72_70,  // printf
    48'h6E_72_75_74_65_72   // return
  };
  localparam logic [7:0] KW_LEN [KW_COUNT] = '{
    8'd5, 8'd3, 8'd4, 8'd4, 8'd4, 8'd2, 8'd4, 8'd2, 8'd5, 8'd3, 8'd5, 8'd6, 8'd6
  };

  // One result record
  typedef struct packed {
    logic [5:0]  kind;
    logic        err;
    logic        cause;
    logic [7:0]  len;
    logic [15:0] line;
    logic        last;
  } res_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  // Single-character operator lookup: {hit, kind}
  function automatic logic [6:0] op_single(input logic [7:0] b);
    logic [6:0] r;
    case (b)
      8'h2B:   r = {1'b1, 6'd17};
      8'h2D:   r = {1'b1, 6'd18};
      8'h2A:   r = {1'b1, 6'd19};
      8'h2F:   r = {1'b1, 6'd20};
      8'h3C:   r = {1'b1, 6'd21};
      8'h3E:   r = {1'b1, 6'd22};
      8'h3D:   r = {1'b1, 6'd23};
      8'h3B:   r = {1'b1, 6'd24};
      8'h2C:   r = {1'b1, 6'd25};
      8'h28:   r = {1'b1, 6'd26};
      8'h29:   r = {1'b1, 6'd27};
      8'h5B:   r = {1'b1, 6'd28};
      8'h5D:   r = {1'b1, 6'd29};
      8'h7B:   r = {1'b1, 6'd30};
      8'h7D:   r = {1'b1, 6'd31};
      default: r = {1'b0, KIND_NONE};
    endcase
    return r;
  endfunction

  // Keyword or identifier kind of a finished word
  function automatic logic [5:0] word_kind(input logic [KW_CHARS-1:0][7:0] p,
                                           input logic [7:0] held,
                                           input logic ovf);
    logic [5:0] kind;
    logic       hit;
    kind = KIND_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      hit = !ovf && (held == KW_LEN[k]);
      for (int i = 0; i < KW_CHARS; i++) begin
        if (8'(i) < KW_LEN[k] && p[i] != KW_TEXT[k][i]) hit = 1'b0;
      end
      if (hit) kind = 6'(k);
    end
    return kind;
  endfunction

  function automatic res_t mk_res(input logic [5:0] kind, input logic err,
                                  input logic cause, input logic [7:0] len,
                                  input logic [15:0] line);
    res_t r;
    r.kind  = kind;
    r.err   = err;
    r.cause = cause;
    r.len   = len;
    r.line  = line;
    r.last  = 1'b0;
    return r;
  endfunction

endpackage

### sv/c_like_token_scanner_top.sv
// Top level of the C-like token scanner: byte stream in, token records out.
//
// The scanner takes one source byte per cycle while the output buffer has room.
// Each byte is scanned in the cycle it is accepted and its results (zero to
// three token or error records) are loaded into a three-entry output buffer
// that drains one record per cycle while m_axis_tready is high. A byte that
// causes at most one record therefore keeps the input at one byte per cycle;
// a byte that causes more records holds off the next byte while the output
// buffer drains, and any output stall adds to that. Line numbers count CR,
// LF and CR LF line ends and saturate at 65535; token lengths saturate at
// min(TokenLenMax, 255). No clearing pass is needed after reset.
module c_like_token_scanner_top
  import cts_pkg::*;
#(
  parameter int TokenLenMax  = TOKEN_LEN_MAX_DEF,
  parameter int KeywordChars = KEYWORD_CHARS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [5:0] token_kind, [13:6] token_length,
                                      // [29:14] line_number, [31:30] zero
  output logic [1:0]  m_axis_tuser,   // [0] is_error, [1] error_cause
  output logic        m_axis_tlast    // last_result
);

  localparam int LenCap = (TokenLenMax < 255) ? TokenLenMax : 255;
  localparam int PidxW  = (KeywordChars > 1) ? $clog2(KeywordChars) : 1;

  // Scanner state
  logic [2:0]  mode_q, mode_d;
  logic [7:0]  held_q, held_d;
  logic        ovf_q, ovf_d;
  logic        bs_q, bs_d;
  logic [15:0] line_q, line_d;
  logic        acr_q, acr_d;
  logic [7:0]  prefix_q [KeywordChars];

  // Prefix write port
  logic             pre_we;
  logic [PidxW-1:0] pre_idx;

  // Results of the current byte
  res_t       res [3];
  logic [1:0] n;

  // Output buffer
  res_t       buf_q [3];
  logic [1:0] cnt_q;

  logic [7:0] b;
  logic       eot, accept, pop;
  logic       do_flush, do_start, do_clear, do_add, fin, unm, inc;
  logic [6:0] op;
  logic [6:0] held_op;
  logic [5:0] sym_kind;
  logic       char_ok;
  logic [KW_CHARS-1:0][7:0] kw_p;

  assign b      = s_axis_tdata;
  assign eot    = s_axis_tlast;
  assign pop    = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_axis_tready);
  assign accept = s_axis_tvalid && s_axis_tready;

  // Gather the keyword-width view of the prefix
  always_comb begin
    for (int i = 0; i < KW_CHARS; i++) kw_p[i] = prefix_q[i];
  end

  assign op      = op_single(b);
  assign held_op = op_single(prefix_q[0]);

  // Two-character operator kind from the held first character
  always_comb begin
    if (prefix_q[0] == CH_LT)      sym_kind = KIND_OP_LE;
    else if (prefix_q[0] == CH_GT) sym_kind = KIND_OP_GE;
    else if (prefix_q[0] == CH_EQ) sym_kind = KIND_OP_EQ;
    else                           sym_kind = KIND_OP_NE;
  end

  assign char_ok = (held_q == 8'd1) &&
                   (prefix_q[0] == CH_PLUS || prefix_q[0] == CH_MINUS ||
                    prefix_q[0] == CH_STAR || prefix_q[0] == CH_SLASH ||
                    is_letter(prefix_q[0]) || is_digit(prefix_q[0]));

  // Scan one byte: next state and up to three records
  always_comb begin
    mode_d   = mode_q;
    held_d   = held_q;
    ovf_d    = ovf_q;
    bs_d     = bs_q;
    line_d   = line_q;
    acr_d    = acr_q;
    pre_we   = 1'b0;
    pre_idx  = '0;
    n        = 2'd0;
    do_flush = 1'b0;
    do_start = 1'b0;
    do_clear = 1'b0;
    do_add   = 1'b0;
    fin      = 1'b0;
    unm      = 1'b0;
    inc      = 1'b0;
    for (int i = 0; i < 3; i++) res[i] = '0;

    // Decide what this byte does
    if (eot) begin
      do_flush = 1'b1;
      acr_d    = 1'b0;
    end else if (b == CH_CR) begin
      do_flush = 1'b1;
      inc      = 1'b1;
      acr_d    = 1'b1;
    end else if (b == CH_LF) begin
      if (acr_q) begin
        acr_d = 1'b0;
      end else begin
        do_flush = 1'b1;
        inc      = 1'b1;
      end
    end else begin
      acr_d = 1'b0;
      unique case (mode_q)
        M_IDENT: begin
          if (is_letter(b) || is_digit(b)) do_add = 1'b1;
          else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        M_NUMBER: begin
          if (is_digit(b)) do_add = 1'b1;
          else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        M_STRING: begin
          if (b == CH_DQUOTE && !bs_q) begin
            res[n]   = mk_res(KIND_STRING, 1'b0, 1'b0, held_q, line_q);
            n        = n + 2'd1;
            do_clear = 1'b1;
          end else begin
            do_add = 1'b1;
            bs_d   = (b == CH_BSLASH);
          end
        end
        M_CHAR_OPEN: begin
          do_add = 1'b1;
          mode_d = (b == CH_BSLASH) ? M_CHAR_ESC : M_CHAR_CLOSE;
        end
        M_CHAR_ESC: begin
          do_add = 1'b1;
          mode_d = M_CHAR_CLOSE;
        end
        M_CHAR_CLOSE: begin
          fin      = 1'b1;
          unm      = (b != CH_QUOTE);
          do_clear = 1'b1;
        end
        M_SYMBOL: begin
          if (b == CH_EQ) begin
            res[n]   = mk_res(sym_kind, 1'b0, 1'b0, 8'd2, line_q);
            n        = n + 2'd1;
            do_clear = 1'b1;
          end else begin
            do_flush = 1'b1;
            do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase
    end

    // Flush the pending token
    if (do_flush) begin
      do_clear = 1'b1;
      unique case (mode_q) inside
        M_IDENT: begin
          res[n] = mk_res(word_kind(kw_p, held_q, ovf_q), 1'b0, 1'b0, held_q, line_q);
          n      = n + 2'd1;
        end
        M_NUMBER: begin
          res[n] = mk_res(KIND_NUMBER, 1'b0, 1'b0, held_q, line_q);
          n      = n + 2'd1;
        end
        M_STRING: begin
          res[n] = mk_res(KIND_STRING, 1'b0, 1'b0, held_q, line_q);
          n      = n + 2'd1;
        end
        M_SYMBOL: begin
          if (held_op[6])
            res[n] = mk_res(held_op[5:0], 1'b0, 1'b0, 8'd1, line_q);
          else
            res[n] = mk_res(KIND_NONE, 1'b1, CAUSE_INVALID, 8'd0, line_q);
          n = n + 2'd1;
        end
        M_CHAR_OPEN, M_CHAR_ESC, M_CHAR_CLOSE: begin
          fin = 1'b1;
          unm = 1'b1;
        end
        default: ;
      endcase
    end

    // Finish a character constant
    if (fin) begin
      if (unm) begin
        res[n] = mk_res(KIND_NONE, 1'b1, CAUSE_UNMATCHED, 8'd0, line_q);
        n      = n + 2'd1;
      end
      if (!char_ok) begin
        res[n] = mk_res(KIND_NONE, 1'b1, CAUSE_INVALID, 8'd0, line_q);
        n      = n + 2'd1;
      end
      res[n] = mk_res(KIND_CHAR, 1'b0, 1'b0, held_q, line_q);
      n      = n + 2'd1;
    end

    // Drop the body and return to idle
    if (do_clear) begin
      mode_d = M_IDLE;
      held_d = 8'd0;
      ovf_d  = 1'b0;
      bs_d   = 1'b0;
    end

    // Append the byte to the body
    if (do_add) begin
      if (held_q < 8'(KeywordChars)) begin
        pre_we  = 1'b1;
        pre_idx = held_q[PidxW-1:0];
      end
      if (held_q < 8'(LenCap)) held_d = held_q + 8'd1;
      else                     ovf_d  = 1'b1;
    end

    // Scan the byte from idle
    if (do_start) begin
      held_d = 8'd0;
      ovf_d  = 1'b0;
      bs_d   = 1'b0;
      mode_d = M_IDLE;
      if (is_letter(b) || is_digit(b) || b == CH_BANG || b == CH_LT ||
          b == CH_GT || b == CH_EQ) begin
        mode_d  = is_letter(b) ? M_IDENT : is_digit(b) ? M_NUMBER : M_SYMBOL;
        held_d  = 8'd1;
        pre_we  = 1'b1;
        pre_idx = '0;
      end else if (b == CH_QUOTE) begin
        mode_d = M_CHAR_OPEN;
      end else if (b == CH_DQUOTE) begin
        mode_d = M_STRING;
      end else if (op[6]) begin
        res[n] = mk_res(op[5:0], 1'b0, 1'b0, 8'd1, line_q);
        n      = n + 2'd1;
      end
    end

    // Advance the line counter
    if (inc && line_q != 16'hFFFF) line_d = line_q + 16'd1;

    // Mark the final record of this byte
    for (int i = 0; i < 3; i++) res[i].last = (n != 2'd0) && (2'(i) == n - 2'd1);
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      held_q <= 8'd0;
      ovf_q  <= 1'b0;
      bs_q   <= 1'b0;
      line_q <= 16'd1;
      acr_q  <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      held_q <= held_d;
      ovf_q  <= ovf_d;
      bs_q   <= bs_d;
      line_q <= line_d;
      acr_q  <= acr_d;
    end
  end

  // Body prefix store
  always_ff @(posedge clk_i) begin
    if (accept && pre_we) prefix_q[pre_idx] <= b;
  end

  // Output buffer: load on accept, shift on pop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (accept) begin
      cnt_q <= n;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_q <= res;
    end else if (pop) begin
      buf_q[0] <= buf_q[1];
      buf_q[1] <= buf_q[2];
    end
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = {2'b00, buf_q[0].line, buf_q[0].len, buf_q[0].kind};
  assign m_axis_tuser  = {buf_q[0].cause, buf_q[0].err};
  assign m_axis_tlast  = buf_q[0].last;

endmodule

### bench/c_like_token_scanner_top_test.sv
// Self-checking bench for the C-like token scanner: streams source text in, checks token records.
`timescale 1ns / 1ps

module c_like_token_scanner_top_test;
  import cts_pkg::*;

  localparam int          RESET_CYCLES     = 9;
  localparam int          RANDOM_ITEMS     = 60;
  localparam int          SINK_HOLD_CYCLES = 300;
  localparam int          TAIL_CYCLES      = 20;
  localparam int unsigned TIMEOUT_NS       = 200_000;
  localparam int unsigned LEN_CAP          = 255;
  localparam int unsigned LINE_MAX         = 65535;
  localparam logic [5:0]  KIND_OP_BASE     = 6'd17;

  // Expected token or error record
  typedef struct packed {
    logic [5:0]  kind;
    logic        err;
    logic        cause;
    logic [7:0]  len;
    logic [15:0] line;
    logic        last;
  } token_rec_t;

  // Single-character operators in kind order
  localparam logic [7:0] OP_BYTES [15] = '{
    "+", "-", "*", "/", "<", ">", "=", ";", ",", "(", ")", "[", "]", "{", "}"
  };

  string kw_words [KW_COUNT] = '{
    "const", "int", "char", "void", "main", "if", "else",
    "do", "while", "for", "scanf", "printf", "return"
  };
  string word_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  string alnum_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string digit_chars = "0123456789";
  string arith_chars = "+-*/";
  string pair_heads  = "<>=!";

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'h00;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Scanner state as the bench tracks it
  logic [2:0]  sc_mode;
  logic [7:0]  sc_prefix [KW_CHARS];
  int unsigned sc_held;
  int unsigned sc_line;
  bit          sc_after_cr;
  logic [7:0]  sc_prev;
  bit          sc_ovf;

  token_rec_t  step_tokens[$];
  token_rec_t  pending_tokens[$];
  logic [7:0]  text_q[$];
  int unsigned mismatches    = 0;
  bit          pace_free     = 1'b0;
  bit          sink_hold_req = 1'b0;

  c_like_token_scanner_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic bit letter_byte(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic bit digit_byte(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic int op_slot(input logic [7:0] b);
    for (int i = 0; i < 15; i++) begin
      if (OP_BYTES[i] == b) return i;
    end
    return -1;
  endfunction

  function automatic void reset_scanner_copy();
    sc_mode     = M_IDLE;
    foreach (sc_prefix[i]) sc_prefix[i] = 8'h00;
    sc_held     = 0;
    sc_line     = 1;
    sc_after_cr = 1'b0;
    sc_prev     = 8'h00;
    sc_ovf      = 1'b0;
  endfunction

  // Queue one record for the byte being scanned, three at most
  function automatic void put_token(input logic [5:0] kind, input logic err,
                                    input logic cause, input int unsigned len);
    token_rec_t r;
    if (step_tokens.size() >= 3) return;
    r.kind  = kind;
    r.err   = err;
    r.cause = cause;
    r.len   = 8'(len);
    r.line  = 16'(sc_line);
    r.last  = 1'b0;
    step_tokens = {step_tokens, r};
  endfunction

  function automatic void append_char(input logic [7:0] b);
    if (sc_held < KW_CHARS) sc_prefix[sc_held] = b;
    if (sc_held < LEN_CAP) sc_held++;
    else sc_ovf = 1'b1;
  endfunction

  function automatic void clear_body();
    sc_held = 0;
    sc_ovf  = 1'b0;
    sc_prev = 8'h00;
  endfunction

  // Keyword only when the whole body matches
  function automatic logic [5:0] classify_word();
    int unsigned n;
    bit          hit;
    for (int k = 0; k < KW_COUNT; k++) begin
      n = kw_words[k].len();
      if (sc_ovf || n != sc_held || n > KW_CHARS) continue;
      hit = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (sc_prefix[i] != kw_words[k][i]) hit = 1'b0;
      end
      if (hit) return 6'(k);
    end
    return KIND_IDENT;
  endfunction

  function automatic void lone_operator(input logic [7:0] b);
    int idx;
    idx = op_slot(b);
    if (idx >= 0) put_token(KIND_OP_BASE + 6'(idx), 1'b0, 1'b0, 1);
    else put_token(KIND_NONE, 1'b1, CAUSE_INVALID, 0);
  endfunction

  // Close a char constant: quote error, content error, then the token
  function automatic void close_char(input bit unmatched);
    logic [7:0] c;
    c = sc_prefix[0];
    if (unmatched) put_token(KIND_NONE, 1'b1, CAUSE_UNMATCHED, 0);
    if (!(sc_held == 1 && (c == "+" || c == "-" || c == "*" || c == "/" ||
                           letter_byte(c) || digit_byte(c))))
      put_token(KIND_NONE, 1'b1, CAUSE_INVALID, 0);
    put_token(KIND_CHAR, 1'b0, 1'b0, sc_held);
  endfunction

  function automatic void flush_pending();
    case (sc_mode) inside
      M_IDENT:  put_token(classify_word(), 1'b0, 1'b0, sc_held);
      M_NUMBER: put_token(KIND_NUMBER, 1'b0, 1'b0, sc_held);
      M_STRING: put_token(KIND_STRING, 1'b0, 1'b0, sc_held);
      M_SYMBOL: lone_operator(sc_prefix[0]);
      M_CHAR_OPEN, M_CHAR_ESC, M_CHAR_CLOSE: close_char(1'b1);
      default: ;
    endcase
    sc_mode = M_IDLE;
    clear_body();
  endfunction

  function automatic void start_token(input logic [7:0] b);
    int idx;
    clear_body();
    if (letter_byte(b)) begin
      sc_mode = M_IDENT;
      append_char(b);
    end else if (digit_byte(b)) begin
      sc_mode = M_NUMBER;
      append_char(b);
    end else if (b == CH_QUOTE) begin
      sc_mode = M_CHAR_OPEN;
    end else if (b == CH_DQUOTE) begin
      sc_mode = M_STRING;
    end else if (b == CH_BANG || b == CH_LT || b == CH_GT || b == CH_EQ) begin
      sc_mode = M_SYMBOL;
      append_char(b);
    end else begin
      sc_mode = M_IDLE;
      idx = op_slot(b);
      if (idx >= 0) put_token(KIND_OP_BASE + 6'(idx), 1'b0, 1'b0, 1);
    end
  endfunction

  function automatic void line_end();
    flush_pending();
    if (sc_line < LINE_MAX) sc_line++;
  endfunction

  // Scan one accepted byte and queue the records it should produce
  function automatic void scan_text_byte(input logic [7:0] b, input logic eot);
    logic [5:0] pair_kind;
    step_tokens.delete();
    if (eot) begin
      flush_pending();
      sc_after_cr = 1'b0;
    end else if (b == CH_CR) begin
      line_end();
      sc_after_cr = 1'b1;
    end else if (b == CH_LF) begin
      if (sc_after_cr) sc_after_cr = 1'b0;
      else line_end();
    end else begin
      sc_after_cr = 1'b0;
      case (sc_mode)
        M_IDENT: begin
          if (letter_byte(b) || digit_byte(b)) append_char(b);
          else begin
            flush_pending();
            start_token(b);
          end
        end
        M_NUMBER: begin
          if (digit_byte(b)) append_char(b);
          else begin
            flush_pending();
            start_token(b);
          end
        end
        M_STRING: begin
          if (b == CH_DQUOTE && sc_prev != CH_BSLASH) begin
            put_token(KIND_STRING, 1'b0, 1'b0, sc_held);
            sc_mode = M_IDLE;
            clear_body();
          end else begin
            append_char(b);
            sc_prev = b;
          end
        end
        M_CHAR_OPEN: begin
          append_char(b);
          sc_mode = (b == CH_BSLASH) ? M_CHAR_ESC : M_CHAR_CLOSE;
        end
        M_CHAR_ESC: begin
          append_char(b);
          sc_mode = M_CHAR_CLOSE;
        end
        M_CHAR_CLOSE: begin
          close_char(b != CH_QUOTE);
          sc_mode = M_IDLE;
          clear_body();
        end
        M_SYMBOL: begin
          if (b == CH_EQ) begin
            case (sc_prefix[0])
              CH_LT:   pair_kind = KIND_OP_LE;
              CH_GT:   pair_kind = KIND_OP_GE;
              CH_EQ:   pair_kind = KIND_OP_EQ;
              default: pair_kind = KIND_OP_NE;
            endcase
            put_token(pair_kind, 1'b0, 1'b0, 2);
            sc_mode = M_IDLE;
            clear_body();
          end else begin
            flush_pending();
            start_token(b);
          end
        end
        default: start_token(b);
      endcase
    end
    // Mark the final record of this byte
    if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    pending_tokens = {pending_tokens, step_tokens};
  endfunction

  // ------------------------------------------------------------- bus helpers

  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item, wait for acceptance, then predict it
  task automatic send_item(input logic [7:0] b, input logic eot);
    int unsigned n;
    n = pace_free ? 0 : idle_len();
    if (n != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tdata  <= b;
    s_axis_tlast  <= eot;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    scan_text_byte(b, eot);
  endtask

  task automatic send_end();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Append one byte to the text waiting to be sent
  function automatic void put_byte(input logic [7:0] c);
    text_q = {text_q, c};
  endfunction

  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  task automatic send_queued();
    while (text_q.size() != 0) send_item(text_q.pop_front(), 1'b0);
  endtask

  task automatic send_text(input string s);
    queue_text(s);
    send_queued();
  endtask

  // Stop offering and hold until every expected record is back
  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_tokens.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // -------------------------------------------------------------- result side

  // Pace the receiver; honor a long hold when one is requested
  initial begin : result_sink
    int unsigned n;
    forever begin
      @(posedge clk_i);
      if (sink_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk_i);
        sink_hold_req = 1'b0;
      end
      n = pace_free ? 0 : idle_len();
      if (n == 0) m_axis_tready <= 1'b1;
      else begin
        m_axis_tready <= 1'b0;
        repeat (n) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare each accepted record with the oldest expectation
  always @(posedge clk_i) begin : record_check
    token_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_tokens.size() == 0) begin
        report_mismatch($sformatf("record with nothing expected: tdata %h tuser %h tlast %b",
                                  m_axis_tdata, m_axis_tuser, m_axis_tlast));
      end else begin
        want = pending_tokens.pop_front();
        check_field("token_kind", 32'(m_axis_tdata[5:0]), 32'(want.kind));
        check_field("token_length", 32'(m_axis_tdata[13:6]), 32'(want.len));
        check_field("line_number", 32'(m_axis_tdata[29:14]), 32'(want.line));
        check_field("tdata padding", 32'(m_axis_tdata[31:30]), 32'd0);
        check_field("is_error", 32'(m_axis_tuser[0]), 32'(want.err));
        check_field("error_cause", 32'(m_axis_tuser[1]), 32'(want.cause));
        check_field("last_result", 32'(m_axis_tlast), 32'(want.last));
      end
    end
  end

  // ------------------------------------------------------------------- tests

  // Every token class and operator, char and string corner cases, line ends
  task automatic test_directed_text();
    send_text("printf _Z9 042+-*/;,()[]{}< > = <=>===!=!q<");
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    // plain, escaped, unclosed and invalid char constants, then one cut by a line end
    send_text("'a' '\\n' 'ab '?' '");
    send_item(CH_LF, 1'b0);
    // escaped quote inside a string, then a string cut by a lone CR
    send_text("\"s\\\"t\" \"a");
    send_item(CH_CR, 1'b0);
    // ignored bytes at idle
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_text("@");
    // end of text with a word, a char constant and a lone bang pending
    send_text("x");
    send_end();
    send_text("'\\");
    send_end();
    send_text("!");
    send_end();
    wait_all_results();
  endtask

  // Bodies longer than the keyword prefix
  task automatic test_long_bodies();
    send_text("printf");
    repeat (12) send_item("x", 1'b0);
    send_text(" ");
    repeat (10) send_item("7", 1'b0);
    send_text(" \"");
    repeat (9) send_item("q", 1'b0);
    send_text("\"\"");
    repeat (8) send_item("z", 1'b0);
    send_item(CH_CR, 1'b0);
    wait_all_results();
  endtask

  // Hold the receiver off while the sender keeps offering items
  task automatic test_output_stall();
    pace_free     = 1'b1;
    sink_hold_req = 1'b1;
    for (int i = 0; i < 12; i++) begin
      send_text(";(");
      if (i % 6 == 0) begin
        send_text("'");
        send_item(CH_CR, 1'b0);
      end
    end
    pace_free = 1'b0;
    wait_all_results();
  endtask

  // Mostly well-formed token sequences with random content, some noise
  task automatic test_random_text();
    int unsigned counted;
    int unsigned pick;
    int unsigned n;
    bit          cut;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(0, 24) == 0) pace_free = !pace_free;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        queue_text(kw_words[$urandom_range(0, KW_COUNT - 1)]);
      end else if (pick < 30) begin
        // identifier, now and then a keyword with more characters behind it
        if ($urandom_range(0, 2) == 0) queue_text(kw_words[$urandom_range(0, KW_COUNT - 1)]);
        else put_byte(word_chars[$urandom_range(0, 52)]);
        n = $urandom_range(1, 8);
        repeat (n) put_byte(alnum_chars[$urandom_range(0, 62)]);
      end else if (pick < 40) begin
        n = $urandom_range(1, 8);
        repeat (n) put_byte(digit_chars[$urandom_range(0, 9)]);
      end else if (pick < 55) begin
        if ($urandom_range(0, 2) == 0) begin
          put_byte(pair_heads[$urandom_range(0, 3)]);
          put_byte(CH_EQ);
        end else begin
          put_byte(OP_BYTES[$urandom_range(0, 14)]);
        end
      end else if (pick < 65) begin
        // char constant: well formed, escaped, unclosed or cut by a line end
        cut = 1'b0;
        put_byte(CH_QUOTE);
        case ($urandom_range(0, 5)) inside
          0, 1: put_byte(alnum_chars[$urandom_range(0, 62)]);
          2: put_byte(arith_chars[$urandom_range(0, 3)]);
          3: put_byte(8'($urandom_range(32, 126)));
          4: begin
            put_byte(CH_BSLASH);
            put_byte(8'($urandom_range(32, 126)));
          end
          default: begin
            put_byte(CH_LF);
            cut = 1'b1;
          end
        endcase
        if (!cut)
          put_byte(($urandom_range(0, 4) == 0) ? 8'($urandom_range(32, 126)) : CH_QUOTE);
      end else if (pick < 75) begin
        put_byte(CH_DQUOTE);
        n = $urandom_range(0, 12);
        repeat (n) begin
          case ($urandom_range(0, 9))
            0: put_byte(CH_BSLASH);
            1: begin
              put_byte(CH_BSLASH);
              put_byte(CH_DQUOTE);
            end
            default: put_byte(8'($urandom_range(32, 126)));
          endcase
        end
        put_byte(($urandom_range(0, 9) == 0) ? CH_CR : CH_DQUOTE);
      end else if (pick < 85) begin
        case ($urandom_range(0, 5))
          0: put_byte(" ");
          1: put_byte(8'h09);
          2: put_byte(CH_CR);
          3: put_byte(CH_LF);
          4: begin
            put_byte(CH_CR);
            put_byte(CH_LF);
          end
          default: begin
            put_byte(CH_LF);
            put_byte(CH_CR);
          end
        endcase
      end else if (pick < 93) begin
        // symbol head not followed by '='
        put_byte(pair_heads[$urandom_range(0, 3)]);
        put_byte(($urandom_range(0, 3) == 0) ? 8'(" ") : alnum_chars[$urandom_range(0, 62)]);
      end else if (pick < 98) begin
        n = $urandom_range(1, 3);
        repeat (n) put_byte(8'($urandom_range(0, 255)));
      end
      if (pick < 75 && $urandom_range(0, 1) == 1) put_byte(" ");
      if (pick < 75 || (pick >= 85 && pick < 93)) counted += text_q.size();
      send_queued();
      if (pick >= 98) begin
        send_end();
        counted++;
      end
    end
    pace_free = 1'b0;
    wait_all_results();
  endtask

  // Line ends of every form with tokens around them
  task automatic test_line_ends();
    send_text("a");
    send_item(CH_LF, 1'b0);
    send_text("b");
    send_item(CH_CR, 1'b0);
    send_item(CH_LF, 1'b0);
    send_text("c '");
    send_item(CH_CR, 1'b0);
    send_text("d");
    send_end();
    wait_all_results();
  endtask

  initial begin
    reset_scanner_copy();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_text();
    test_long_bodies();
    test_output_stall();
    test_random_text();
    test_line_ends();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
sv/cts_pkg.sv
sv/c_like_token_scanner_top.sv
bench/c_like_token_scanner_top_test.sv
